// ===== design/ksrb_pkg.sv =====
`timescale 1ns / 1ps

package ksrb_pkg;

	// Store geometry
	localparam int MAX_ENTITIES = 1024;
	localparam int IDX_W        = $clog2(MAX_ENTITIES);
	localparam int CNT_W        = $clog2(MAX_ENTITIES + 1);

	// Key halves and fixed port field widths
	localparam int HALF_W      = 32;
	localparam int KEY_W       = 2 * HALF_W;
	localparam int ENT_IDX_W   = 10;
	localparam int RUN_CNT_W   = 11;
	localparam int REC_KIND_W  = 2;

	// Input word kinds
	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_FETCH = 1'b1;

	// Output record kinds
	localparam logic [REC_KIND_W-1:0] REC_ENTRY = 2'd0;
	localparam logic [REC_KIND_W-1:0] REC_BATCH = 2'd1;
	localparam logic [REC_KIND_W-1:0] REC_EMPTY = 2'd2;

	// One stored entity: sort key and load position
	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [IDX_W-1:0] org;
	} ent_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SORT_SEG,
		ST_SORT_RD,
		ST_SORT_WR,
		ST_FETCH_RD,
		ST_FETCH_EVAL,
		ST_EMPTY
	} state_t;

endpackage

// ===== design/key_sort_run_batcher_top.sv =====
`timescale 1ns / 1ps

// Sort-by-key run batcher. A load word (kind 0) stores one entity and gives
// no record; loads past MAX_ENTITIES are dropped and flagged as overflow,
// and loads after the frame is sorted are ignored. A fetch word (kind 1)
// returns one record: entity index entries of a run of equal keys
// (mesh_id:material_id), then that run's batch descriptor, or the empty record
// when nothing is stored. A fetch that finds the data sorted goes through a
// memory read state and an evaluate state, which registers its record and
// holds through any output stall. The first fetch of a frame of two or more
// entities first runs a stable bottom-up merge sort through one shared
// compare-and-write step over two ping-pong memories, each with one write and
// two read ports: each element of each pass goes through a read state and a
// write state, and each merged segment and each pass through a setup state.
// The block takes no word while sorting or while a fetch is in flight. After
// the record marked last the frame clears; no clearing pass runs after reset.
module key_sort_run_batcher_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic                                 kind,
	input  logic [ksrb_pkg::HALF_W-1:0]          mesh_id,
	input  logic [ksrb_pkg::HALF_W-1:0]          material_id,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [ksrb_pkg::REC_KIND_W-1:0]      record_kind,
	output logic [ksrb_pkg::HALF_W-1:0]          batch_mesh,
	output logic [ksrb_pkg::HALF_W-1:0]          batch_material,
	output logic [ksrb_pkg::ENT_IDX_W-1:0]       entity_index,
	output logic [ksrb_pkg::ENT_IDX_W-1:0]       first_index,
	output logic [ksrb_pkg::RUN_CNT_W-1:0]       run_count,
	output logic                                 overflow,
	output logic                                 last
);

	localparam int CNT_W = ksrb_pkg::CNT_W;
	localparam int IDX_W = ksrb_pkg::IDX_W;
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(ksrb_pkg::MAX_ENTITIES);

	ksrb_pkg::state_t state_q, state_d;

	// Frame state
	logic [CNT_W-1:0] count_q;
	logic             sorted_q;
	logic             dropped_q;
	logic [CNT_W-1:0] read_pos_q;
	logic [CNT_W-1:0] run_start_q;
	logic             cur_q;

	// Merge sort cursors
	logic [CNT_W-1:0] width_q;
	logic [CNT_W-1:0] lo_q;
	logic [CNT_W-1:0] mid_q;
	logic [CNT_W-1:0] hi_q;
	logic [CNT_W-1:0] a_q;
	logic [CNT_W-1:0] b_q;
	logic [CNT_W-1:0] k_q;
	logic             src_q;

	// Ping-pong memories
	ksrb_pkg::ent_t bank0_mem [ksrb_pkg::MAX_ENTITIES];
	ksrb_pkg::ent_t bank1_mem [ksrb_pkg::MAX_ENTITIES];
	ksrb_pkg::ent_t rd0a_q, rd0b_q, rd1a_q, rd1b_q;
	logic           rd_sel_q;

	// Output register
	logic                                out_valid_q;
	logic [ksrb_pkg::REC_KIND_W-1:0]     rec_kind_q;
	logic [ksrb_pkg::HALF_W-1:0]         mesh_q;
	logic [ksrb_pkg::HALF_W-1:0]         material_q;
	logic [ksrb_pkg::ENT_IDX_W-1:0]      ent_idx_q;
	logic [ksrb_pkg::ENT_IDX_W-1:0]      first_idx_q;
	logic [ksrb_pkg::RUN_CNT_W-1:0]      run_cnt_q;
	logic                                overflow_q;
	logic                                last_q;

	// Combinational control
	logic           in_fire;
	logic           is_fetch;
	logic           sorting;
	logic           out_free;
	logic           out_load;
	logic           load_wr;
	logic           sort_wr;
	logic           wr_en;
	logic           wr_bank;
	logic [IDX_W-1:0] wr_addr;
	ksrb_pkg::ent_t wr_data;
	logic [IDX_W-1:0] rd_addr_a;
	logic [IDX_W-1:0] rd_addr_b;
	ksrb_pkg::ent_t ent_a;
	ksrb_pkg::ent_t ent_b;
	logic           take_left;
	logic           is_entry;
	logic           is_last;
	logic [CNT_W:0] lo_w;
	logic [CNT_W:0] lo_2w;
	logic [CNT_W:0] w2;
	logic           pass_end;
	logic           sort_done;
	logic [CNT_W-1:0] k_nx;
	logic [CNT_W-1:0] run_len;

	assign in_fire  = in_valid && in_ready;
	assign is_fetch = (kind == ksrb_pkg::KIND_FETCH);
	assign out_free = !out_valid_q || out_ready;
	assign sorting  = (state_q == ksrb_pkg::ST_SORT_SEG) || (state_q == ksrb_pkg::ST_SORT_RD) ||
		(state_q == ksrb_pkg::ST_SORT_WR);

	// Read data from the bank that was addressed last cycle
	assign ent_a = rd_sel_q ? rd1a_q : rd0a_q;
	assign ent_b = rd_sel_q ? rd1b_q : rd0b_q;

	// Merge step: left wins ties, which keeps load order
	assign take_left = (a_q < mid_q) && ((b_q >= hi_q) || (ent_a.key <= ent_b.key));
	assign k_nx      = k_q + 1'b1;

	// Segment bounds
	assign lo_w      = {1'b0, lo_q} + {1'b0, width_q};
	assign lo_2w     = {1'b0, lo_q} + {width_q, 1'b0};
	assign w2        = {width_q, 1'b0};
	assign pass_end  = (lo_q >= count_q);
	assign sort_done = (w2 >= {1'b0, count_q});

	// Fetch evaluation
	assign is_entry = (read_pos_q < count_q) &&
		((read_pos_q == run_start_q) || (ent_b.key == ent_a.key));
	assign is_last  = (read_pos_q >= count_q);
	assign run_len  = read_pos_q - run_start_q;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ksrb_pkg::ST_IDLE: begin
				if (in_fire && is_fetch) begin
					if (count_q == '0) begin
						state_d = ksrb_pkg::ST_EMPTY;
					end else if (sorted_q || (count_q == CNT_W'(1))) begin
						state_d = ksrb_pkg::ST_FETCH_RD;
					end else begin
						state_d = ksrb_pkg::ST_SORT_SEG;
					end
				end
			end
			ksrb_pkg::ST_SORT_SEG: begin
				if (!pass_end) begin
					state_d = ksrb_pkg::ST_SORT_RD;
				end else if (sort_done) begin
					state_d = ksrb_pkg::ST_FETCH_RD;
				end
			end
			ksrb_pkg::ST_SORT_RD:  state_d = ksrb_pkg::ST_SORT_WR;
			ksrb_pkg::ST_SORT_WR: begin
				state_d = (k_nx == hi_q) ? ksrb_pkg::ST_SORT_SEG : ksrb_pkg::ST_SORT_RD;
			end
			ksrb_pkg::ST_FETCH_RD: state_d = ksrb_pkg::ST_FETCH_EVAL;
			ksrb_pkg::ST_FETCH_EVAL: begin
				if (out_free) begin
					state_d = ksrb_pkg::ST_IDLE;
				end
			end
			ksrb_pkg::ST_EMPTY: begin
				if (out_free) begin
					state_d = ksrb_pkg::ST_IDLE;
				end
			end
			default: state_d = ksrb_pkg::ST_IDLE;
		endcase
	end

	// Control outputs and memory port steering
	always_comb begin
		in_ready  = (state_q == ksrb_pkg::ST_IDLE);
		out_load  = ((state_q == ksrb_pkg::ST_FETCH_EVAL) || (state_q == ksrb_pkg::ST_EMPTY)) &&
			out_free;
		load_wr   = in_fire && !is_fetch && !sorted_q && (count_q < MAX_CNT);
		sort_wr   = (state_q == ksrb_pkg::ST_SORT_WR);
		wr_en     = load_wr || sort_wr;
		wr_bank   = sort_wr ? ~src_q : cur_q;
		wr_addr   = sort_wr ? k_q[IDX_W-1:0] : count_q[IDX_W-1:0];
		if (sort_wr) begin
			wr_data = take_left ? ent_a : ent_b;
		end else begin
			wr_data.key = {mesh_id, material_id};
			wr_data.org = count_q[IDX_W-1:0];
		end
		rd_addr_a = sorting ? a_q[IDX_W-1:0] : run_start_q[IDX_W-1:0];
		rd_addr_b = sorting ? b_q[IDX_W-1:0] : read_pos_q[IDX_W-1:0];
	end

	// Memories: one write port, two registered read ports each
	always_ff @(posedge clk) begin
		if (wr_en && !wr_bank) begin
			bank0_mem[wr_addr] <= wr_data;
		end
		rd0a_q <= bank0_mem[rd_addr_a];
		rd0b_q <= bank0_mem[rd_addr_b];
	end

	always_ff @(posedge clk) begin
		if (wr_en && wr_bank) begin
			bank1_mem[wr_addr] <= wr_data;
		end
		rd1a_q <= bank1_mem[rd_addr_a];
		rd1b_q <= bank1_mem[rd_addr_b];
	end

	// State register and frame bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ksrb_pkg::ST_IDLE;
			count_q     <= '0;
			sorted_q    <= 1'b0;
			dropped_q   <= 1'b0;
			read_pos_q  <= '0;
			run_start_q <= '0;
			cur_q       <= 1'b0;
			src_q       <= 1'b0;
			rd_sel_q    <= 1'b0;
			width_q     <= '0;
			lo_q        <= '0;
			mid_q       <= '0;
			hi_q        <= '0;
			a_q         <= '0;
			b_q         <= '0;
			k_q         <= '0;
		end else begin
			state_q  <= state_d;
			rd_sel_q <= sorting ? src_q : cur_q;
			unique case (state_q)
				ksrb_pkg::ST_IDLE: begin
					if (in_fire && !is_fetch && !sorted_q) begin
						if (count_q < MAX_CNT) begin
							count_q <= count_q + 1'b1;
						end else begin
							dropped_q <= 1'b1;
						end
					end
					if (in_fire && is_fetch && !sorted_q && (count_q != '0)) begin
						if (count_q == CNT_W'(1)) begin
							sorted_q    <= 1'b1;
							read_pos_q  <= '0;
							run_start_q <= '0;
						end else begin
							width_q <= CNT_W'(1);
							lo_q    <= '0;
							src_q   <= cur_q;
						end
					end
				end
				ksrb_pkg::ST_SORT_SEG: begin
					if (!pass_end) begin
						mid_q <= (lo_w < {1'b0, count_q}) ? lo_w[CNT_W-1:0] : count_q;
						hi_q  <= (lo_2w < {1'b0, count_q}) ? lo_2w[CNT_W-1:0] : count_q;
						a_q   <= lo_q;
						b_q   <= (lo_w < {1'b0, count_q}) ? lo_w[CNT_W-1:0] : count_q;
						k_q   <= lo_q;
					end else if (sort_done) begin
						cur_q       <= ~src_q;
						sorted_q    <= 1'b1;
						read_pos_q  <= '0;
						run_start_q <= '0;
					end else begin
						width_q <= w2[CNT_W-1:0];
						lo_q    <= '0;
						src_q   <= ~src_q;
					end
				end
				ksrb_pkg::ST_SORT_WR: begin
					if (take_left) begin
						a_q <= a_q + 1'b1;
					end else begin
						b_q <= b_q + 1'b1;
					end
					k_q <= k_nx;
					if (k_nx == hi_q) begin
						lo_q <= hi_q;
					end
				end
				ksrb_pkg::ST_FETCH_EVAL: begin
					if (out_free) begin
						if (is_entry) begin
							read_pos_q <= read_pos_q + 1'b1;
						end else if (is_last) begin
							count_q     <= '0;
							sorted_q    <= 1'b0;
							dropped_q   <= 1'b0;
							read_pos_q  <= '0;
							run_start_q <= '0;
						end else begin
							run_start_q <= read_pos_q;
						end
					end
				end
				ksrb_pkg::ST_EMPTY: begin
					if (out_free) begin
						count_q     <= '0;
						sorted_q    <= 1'b0;
						dropped_q   <= 1'b0;
						read_pos_q  <= '0;
						run_start_q <= '0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			overflow_q <= dropped_q;
			if (state_q == ksrb_pkg::ST_EMPTY) begin
				rec_kind_q  <= ksrb_pkg::REC_EMPTY;
				mesh_q      <= '0;
				material_q  <= '0;
				ent_idx_q   <= '0;
				first_idx_q <= '0;
				run_cnt_q   <= '0;
				last_q      <= 1'b1;
			end else begin
				mesh_q      <= ent_a.key[ksrb_pkg::KEY_W-1:ksrb_pkg::HALF_W];
				material_q  <= ent_a.key[ksrb_pkg::HALF_W-1:0];
				first_idx_q <= ksrb_pkg::ENT_IDX_W'(run_start_q);
				if (is_entry) begin
					rec_kind_q <= ksrb_pkg::REC_ENTRY;
					ent_idx_q  <= ksrb_pkg::ENT_IDX_W'(ent_b.org);
					run_cnt_q  <= '0;
					last_q     <= 1'b0;
				end else begin
					rec_kind_q <= ksrb_pkg::REC_BATCH;
					ent_idx_q  <= '0;
					run_cnt_q  <= ksrb_pkg::RUN_CNT_W'(run_len);
					last_q     <= is_last;
				end
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign record_kind    = rec_kind_q;
	assign batch_mesh     = mesh_q;
	assign batch_material = material_q;
	assign entity_index   = ent_idx_q;
	assign first_index    = first_idx_q;
	assign run_count      = run_cnt_q;
	assign overflow       = overflow_q;
	assign last           = last_q;

	// Merge cursors: every written slot came from exactly one side
	a_merge_balance: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ksrb_pkg::ST_SORT_RD) || (state_q == ksrb_pkg::ST_SORT_WR)) |->
		((k_q == a_q + b_q - mid_q) && (a_q <= mid_q) && (b_q <= hi_q) && (k_q < hi_q)))
		else $error("merge cursors out of step");

	// A descriptor never closes an empty run
	a_batch_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (rec_kind_q == ksrb_pkg::REC_BATCH)) |-> (run_cnt_q != '0))
		else $error("batch descriptor with zero count");

	// Loading the final record clears the frame
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && ((state_q == ksrb_pkg::ST_EMPTY) || (!is_entry && is_last))) |=>
		((count_q == '0) && !sorted_q && !dropped_q))
		else $error("frame not cleared after last record");

	// Read cursor never passes the fill count
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q <= MAX_CNT) && (read_pos_q <= count_q) && (run_start_q <= read_pos_q))
		else $error("frame cursors out of range");

endmodule

// ===== dv/key_sort_run_batcher_chk.sv =====
`timescale 1ns / 1ps

// Watches both channels of the run batcher. It keeps its own copy of the
// entity store, predicts each record that a fetch word causes, and compares
// every accepted record with the oldest prediction.
module key_sort_run_batcher_chk (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	input  logic                            in_ready,
	input  logic                            kind,
	input  logic [ksrb_pkg::HALF_W-1:0]     mesh_id,
	input  logic [ksrb_pkg::HALF_W-1:0]     material_id,
	input  logic                            out_valid,
	input  logic                            out_ready,
	input  logic [ksrb_pkg::REC_KIND_W-1:0] record_kind,
	input  logic [ksrb_pkg::HALF_W-1:0]     batch_mesh,
	input  logic [ksrb_pkg::HALF_W-1:0]     batch_material,
	input  logic [ksrb_pkg::ENT_IDX_W-1:0]  entity_index,
	input  logic [ksrb_pkg::ENT_IDX_W-1:0]  first_index,
	input  logic [ksrb_pkg::RUN_CNT_W-1:0]  run_count,
	input  logic                            overflow,
	input  logic                            last,
	output int                              fail_count,
	output int                              pending,
	output int                              frames_closed
);

	typedef struct {
		logic [ksrb_pkg::REC_KIND_W-1:0] rkind;
		logic [ksrb_pkg::HALF_W-1:0]     mesh;
		logic [ksrb_pkg::HALF_W-1:0]     mat;
		logic [ksrb_pkg::ENT_IDX_W-1:0]  ent;
		logic [ksrb_pkg::ENT_IDX_W-1:0]  first;
		logic [ksrb_pkg::RUN_CNT_W-1:0]  cnt;
		logic                            ovf;
		logic                            lst;
	} record_t;

	// Shadow copy of the entity store and frame bookkeeping
	logic [ksrb_pkg::KEY_W-1:0]     keys    [ksrb_pkg::MAX_ENTITIES];
	logic [ksrb_pkg::ENT_IDX_W-1:0] origins [ksrb_pkg::MAX_ENTITIES];
	int unsigned                    stored;
	int unsigned                    rd_pos;
	int unsigned                    run_head;
	bit                             sorted;
	bit                             dropped;

	record_t due_q[$];
	record_t got_r;
	record_t want_r;
	int      errors = 0;
	int      closed = 0;

	function automatic void clear_frame();
		stored   = 0;
		sorted   = 0;
		rd_pos   = 0;
		run_head = 0;
		dropped  = 0;
	endfunction

	// Stable insertion sort: equal keys never pass each other
	function automatic void order_by_key();
		logic [ksrb_pkg::KEY_W-1:0]     k;
		logic [ksrb_pkg::ENT_IDX_W-1:0] o;
		int                             j;
		for (int i = 1; i < int'(stored); i++) begin
			k = keys[i];
			o = origins[i];
			j = i;
			while (j > 0 && keys[j-1] > k) begin
				keys[j]    = keys[j-1];
				origins[j] = origins[j-1];
				j--;
			end
			keys[j]    = k;
			origins[j] = o;
		end
	endfunction

	// Apply one accepted word; a fetch queues the record it must produce
	function automatic void take_word(input logic k, input logic [ksrb_pkg::HALF_W-1:0] m,
			input logic [ksrb_pkg::HALF_W-1:0] mt);
		record_t                    r;
		logic [ksrb_pkg::KEY_W-1:0] head_key;
		if (k == ksrb_pkg::KIND_LOAD) begin
			if (sorted)
				return;
			if (stored >= ksrb_pkg::MAX_ENTITIES) begin
				dropped = 1;
				return;
			end
			keys[stored]    = {m, mt};
			origins[stored] = ksrb_pkg::ENT_IDX_W'(stored);
			stored++;
			return;
		end
		r = '{default: '0};
		r.ovf = dropped;
		if (stored == 0) begin
			r.rkind = ksrb_pkg::REC_EMPTY;
			r.lst   = 1'b1;
			clear_frame();
		end else begin
			if (!sorted) begin
				order_by_key();
				sorted   = 1;
				rd_pos   = 0;
				run_head = 0;
			end
			head_key = keys[run_head];
			r.mesh   = head_key[ksrb_pkg::KEY_W-1:ksrb_pkg::HALF_W];
			r.mat    = head_key[ksrb_pkg::HALF_W-1:0];
			r.first  = ksrb_pkg::ENT_IDX_W'(run_head);
			if (rd_pos < stored && (rd_pos == run_head || keys[rd_pos] == head_key)) begin
				r.rkind = ksrb_pkg::REC_ENTRY;
				r.ent   = origins[rd_pos];
				rd_pos++;
			end else begin
				r.rkind  = ksrb_pkg::REC_BATCH;
				r.cnt    = ksrb_pkg::RUN_CNT_W'(rd_pos - run_head);
				run_head = rd_pos;
				if (rd_pos >= stored) begin
					r.lst = 1'b1;
					clear_frame();
				end
			end
		end
		due_q = {due_q, r};
	endfunction

	function automatic void note_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			errors++;
			if (errors <= 20)
				$display("%0t ns: %s mismatch, expected %0h, actual %0h",
					$time, name, want, got);
		end
	endfunction

	// Sample both channels at the edge where words are taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_frame();
			due_q.delete();
			pending       <= 0;
			frames_closed <= closed;
			fail_count    <= errors;
		end else begin
			if (in_valid && in_ready)
				take_word(kind, mesh_id, material_id);
			if (out_valid && out_ready) begin
				got_r.rkind = record_kind;
				got_r.mesh  = batch_mesh;
				got_r.mat   = batch_material;
				got_r.ent   = entity_index;
				got_r.first = first_index;
				got_r.cnt   = run_count;
				got_r.ovf   = overflow;
				got_r.lst   = last;
				if (due_q.size() == 0) begin
					errors++;
					if (errors <= 20)
						$display("%0t ns: record with none expected, kind %0h mesh %0h",
							$time, record_kind, batch_mesh);
				end else begin
					want_r = due_q.pop_front();
					note_field("record_kind", want_r.rkind, got_r.rkind);
					note_field("batch_mesh", want_r.mesh, got_r.mesh);
					note_field("batch_material", want_r.mat, got_r.mat);
					note_field("entity_index", want_r.ent, got_r.ent);
					note_field("first_index", want_r.first, got_r.first);
					note_field("run_count", want_r.cnt, got_r.cnt);
					note_field("overflow", want_r.ovf, got_r.ovf);
					note_field("last", want_r.lst, got_r.lst);
				end
				if (last === 1'b1)
					closed++;
			end
			pending       <= due_q.size();
			frames_closed <= closed;
			fail_count    <= errors;
		end
	end

endmodule

// ===== dv/key_sort_run_batcher_top_tb.sv =====
`timescale 1ns / 1ps

module key_sort_run_batcher_top_tb;

	localparam int unsigned CYCLE_LIMIT = 1_000_000;
	localparam int          RANDOM_WORDS = 380;

	logic                            clk;
	logic                            arst_n;
	logic                            in_valid;
	logic                            in_ready;
	logic                            kind;
	logic [ksrb_pkg::HALF_W-1:0]     mesh_id;
	logic [ksrb_pkg::HALF_W-1:0]     material_id;
	logic                            out_valid;
	logic                            out_ready = 1'b0;
	logic [ksrb_pkg::REC_KIND_W-1:0] record_kind;
	logic [ksrb_pkg::HALF_W-1:0]     batch_mesh;
	logic [ksrb_pkg::HALF_W-1:0]     batch_material;
	logic [ksrb_pkg::ENT_IDX_W-1:0]  entity_index;
	logic [ksrb_pkg::ENT_IDX_W-1:0]  first_index;
	logic [ksrb_pkg::RUN_CNT_W-1:0]  run_count;
	logic                            overflow;
	logic                            last;

	int          fail_count;
	int          pending;
	int          frames_closed;
	bit          quiet;
	int          stall_left = 2;
	int          stall_draw;
	int unsigned cycles;
	int          n_loads;
	int          n_fetches;
	int          n_strays;
	int          n_frames;
	int          n_random;

	key_sort_run_batcher_top DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.kind           (kind),
		.mesh_id        (mesh_id),
		.material_id    (material_id),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.record_kind    (record_kind),
		.batch_mesh     (batch_mesh),
		.batch_material (batch_material),
		.entity_index   (entity_index),
		.first_index    (first_index),
		.run_count      (run_count),
		.overflow       (overflow),
		.last           (last)
	);

	key_sort_run_batcher_chk u_chk (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.kind           (kind),
		.mesh_id        (mesh_id),
		.material_id    (material_id),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.record_kind    (record_kind),
		.batch_mesh     (batch_mesh),
		.batch_material (batch_material),
		.entity_index   (entity_index),
		.first_index    (first_index),
		.run_count      (run_count),
		.overflow       (overflow),
		.last           (last),
		.fail_count     (fail_count),
		.pending        (pending),
		.frames_closed  (frames_closed)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int draw_gap(input bit calm);
		return calm ? 0 : $urandom_range(0, 13);
	endfunction

	// Sink side: after each taken record, drop ready for a drawn number of cycles
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			if (stall_left == 1)
				out_ready <= 1'b1;
		end else if (out_valid && out_ready) begin
			stall_draw = draw_gap(quiet);
			if (stall_draw > 0) begin
				out_ready  <= 1'b0;
				stall_left <= stall_draw;
			end
		end
	end

	// Hold off a drawn gap, then present one word until it is taken
	task automatic send_word(input logic k, input logic [ksrb_pkg::HALF_W-1:0] m,
			input logic [ksrb_pkg::HALF_W-1:0] mt);
		int gap;
		gap = draw_gap(quiet);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		kind        <= k;
		mesh_id     <= m;
		material_id <= mt;
		do @(posedge clk); while (!in_ready);
	endtask

	// Release the input and wait until every predicted record has come back
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic load_word(input logic [ksrb_pkg::HALF_W-1:0] m,
			input logic [ksrb_pkg::HALF_W-1:0] mt);
		send_word(ksrb_pkg::KIND_LOAD, m, mt);
		n_loads++;
	endtask

	// Fetch until the frame closes; stray loads land mid-output now and then
	task automatic fetch_frame();
		int closed0;
		closed0 = frames_closed;
		while (frames_closed == closed0) begin
			if ($urandom_range(0, 7) == 0) begin
				send_word(ksrb_pkg::KIND_LOAD, $urandom, $urandom);
				n_strays++;
			end else begin
				send_word(ksrb_pkg::KIND_FETCH, $urandom, $urandom);
				n_fetches++;
			end
			if ($urandom_range(0, 1) == 1)
				drain();
		end
		drain();
		n_frames++;
	endtask

	function automatic logic [ksrb_pkg::HALF_W-1:0] pick_half();
		int r;
		r = $urandom_range(0, 5);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		return $urandom;
	endfunction

	// Main stimulus
	initial begin
		logic [ksrb_pkg::HALF_W-1:0] pool_m [3];
		logic [ksrb_pkg::HALF_W-1:0] pool_t [3];
		int                          n;
		int                          sel;
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		kind        = ksrb_pkg::KIND_LOAD;
		mesh_id     = '0;
		material_id = '0;
		quiet       = 1'b0;
		n_loads     = 0;
		n_fetches   = 0;
		n_strays    = 0;
		n_frames    = 0;
		n_random    = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Fetch with nothing stored gives the empty record
		fetch_frame();

		// Extreme keys, mesh ranking over material, and ties kept in load order
		load_word('1, '1);
		load_word('0, '0);
		load_word('1, '1);
		load_word('0, '1);
		load_word('1, '0);
		load_word('0, '0);
		fetch_frame();

		// Single entity frame
		load_word(32'h0000_0001, 32'h8000_0000);
		fetch_frame();

		// Random frames, mostly small, keys mostly drawn from a small pool to force runs
		while (n_random < RANDOM_WORDS) begin
			quiet = ($urandom_range(0, 3) == 0);
			for (int i = 0; i < 3; i++) begin
				pool_m[i] = pick_half();
				pool_t[i] = pick_half();
			end
			sel = $urandom_range(0, 9);
			if (sel == 0)
				n = 0;
			else if (sel <= 6)
				n = $urandom_range(1, 8);
			else if (sel <= 8)
				n = $urandom_range(9, 24);
			else
				n = $urandom_range(25, 60);
			for (int i = 0; i < n; i++) begin
				if ($urandom_range(0, 3) == 0)
					load_word($urandom, $urandom);
				else
					load_word(pool_m[$urandom_range(0, 2)], pool_t[$urandom_range(0, 2)]);
			end
			n_random += n;
			sel = n_fetches;
			fetch_frame();
			n_random += n_fetches - sel;
		end

		quiet = 1'b0;
		drain();
		repeat (20) @(posedge clk);
		$display("Ran %0d loads, %0d fetches and %0d stray loads over %0d frames,",
			n_loads, n_fetches, n_strays, n_frames);
		$display("with empty and single-entity frames, extreme and tied keys, random stalls.");
		if (fail_count == 0 && pending == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// Watchdog
	initial begin
		cycles = 0;
		while (cycles <= CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Timeout after %0d cycles, %0d records outstanding", cycles, pending);
		$display("Test completed with failures");
		$finish;
	end

endmodule
